[design/sfs_pkg.sv]
// shared constants and the binary32 adder function
package sfs_pkg;
  localparam int unsigned KeyBitsDefault = 24;
  localparam int unsigned KeyWidth = 24;
  localparam logic [31:0] QNaN = 32'h7FC0_0000;

  function automatic logic [31:0] fadd32(input logic [31:0] a_in, input logic [31:0] b_in);
    logic [31:0] a, b;
    logic [7:0] ea, eb;
    logic [26:0] ma, mb, mbs;
    logic [7:0] d;
    logic [27:0] s;
    logic [9:0] e;
    logic [4:0] lz;
    logic [2:0] g;
    logic [24:0] r;
    logic an, bn, ai, bi;
    logic [31:0] res;
    an = (a_in[30:23] == 8'hFF) && (a_in[22:0] != 23'd0);
    bn = (b_in[30:23] == 8'hFF) && (b_in[22:0] != 23'd0);
    ai = (a_in[30:0] == 31'h7F80_0000);
    bi = (b_in[30:0] == 31'h7F80_0000);
    if (b_in[30:0] > a_in[30:0]) begin
      a = b_in; b = a_in;
    end else begin
      a = a_in; b = b_in;
    end
    ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ma = {(a[30:23] != 8'd0), a[22:0], 3'b000};
    mb = {(b[30:23] != 8'd0), b[22:0], 3'b000};
    d = ea - eb;
    if (d >= 8'd27) begin
      mbs = {26'd0, (mb != 27'd0)};
    end else begin
      mbs = (mb >> d) | {26'd0, ((mb & ((27'd1 << d) - 27'd1)) != 27'd0)};
    end
    e = {2'b00, ea};
    lz = 5'd0;
    res = 32'd0;
    if (a[31] == b[31]) begin
      s = {1'b0, ma} + {1'b0, mbs};
      if (s[27]) begin
        s = {1'b0, s[27:2], s[1] | s[0]};
        e = e + 10'd1;
      end
    end else begin
      s = {1'b0, ma} - {1'b0, mbs};
      for (int i = 26; i >= 0; i--) begin
        if (s[i] && lz == 5'd0 && s[26:0] >> (i + 1) == 27'd0) lz = 5'(26 - i);
      end
      if (s[26:0] == 27'd0) lz = 5'd0;
      if ({5'd0, lz} >= e - 10'd1) lz = 5'(e - 10'd1);
      s = s << lz;
      e = e - {5'd0, lz};
    end
    g = s[2:0];
    r = {1'b0, s[26:3]};
    if (g > 3'd4 || (g == 3'd4 && r[0])) r = r + 25'd1;
    if (r[24]) begin
      r = r >> 1;
      e = e + 10'd1;
    end
    if (e >= 10'd255) res = {a[31], 31'h7F80_0000};
    else if (!r[23]) res = {a[31], 8'd0, r[22:0]};
    else res = {a[31], e[7:0], r[22:0]};
    if (a[31] != b[31] && s[26:0] == 27'd0) res = 32'd0;
    if (ai || bi) res = (ai && bi && (a_in[31] != b_in[31])) ? QNaN : (ai ? a_in : b_in);
    if (an || bn) res = QNaN;
    return res;
  endfunction
endpackage

[design/sfs_if.sv]
// valid/ready stream interfaces for edges and results
interface sfs_edge_if import sfs_pkg::*; ();
  logic valid;
  logic ready;
  logic [KeyWidth-1:0] segment_key;
  logic [31:0] feature_value;
  logic end_of_stream;
  modport source(output valid, segment_key, feature_value, end_of_stream, input ready);
  modport sink(input valid, segment_key, feature_value, end_of_stream, output ready);
endinterface

interface sfs_result_if import sfs_pkg::*; ();
  logic valid;
  logic ready;
  logic [KeyWidth-1:0] result_key;
  logic [31:0] segment_sum;
  logic final_result;
  modport source(output valid, result_key, segment_sum, final_result, input ready);
  modport sink(input valid, result_key, segment_sum, final_result, output ready);
endinterface

[design/segmented_float_sum_unit.sv]
// segmented binary32 sum over runs of equal key
//
// usage: edges enter on edge_i (valid/ready) sorted by key; finished
// segment sums leave on result_o. a key change emits the closed segment,
// end_of_stream emits the open segment with final_result set and clears the
// accumulator. an edge that causes two results (key change on the last
// edge) places both in a two-entry output queue.
// throughput: one edge per cycle while edge_i.ready is high; the accumulator add is
// combinational binary32 addition feeding back into the running sum.
// output: a result is written into the registered output queue when the edge
// that closes its segment is accepted; result_o shows the queue head.
// stall: edge_i.ready is high while the output queue has room for two
// results, so the receiver stalling fills the queue and then holds edges.
// reset: accumulator, open flag and output queue are cleared.
module segmented_float_sum_unit import sfs_pkg::*; #(
  parameter int unsigned KEY_BITS = KeyBitsDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  sfs_edge_if.sink     edge_i,
  sfs_result_if.source result_o
);
  typedef struct packed {
    logic [KeyWidth-1:0] key;
    logic [31:0] sum;
    logic fin;
  } res_t;

  localparam logic [KeyWidth-1:0] KeyMask = KeyWidth'((33'd1 << KEY_BITS) - 33'd1);

  logic [31:0] sum_q, sum_d;
  logic [KeyWidth-1:0] key_q, key_d;
  logic open_q, open_d;
  res_t fifo_q [2];
  logic [1:0] cnt_q;
  logic rd_ptr_q, wr_ptr_q;
  logic acc, pop, same;
  logic [1:0] npush;
  res_t r0, r1;
  logic [KeyWidth-1:0] k;

  assign k = edge_i.segment_key & KeyMask;
  assign edge_i.ready = (cnt_q == 2'd0) || (cnt_q == 2'd1 && pop);
  assign acc = edge_i.valid && edge_i.ready;
  assign pop = result_o.valid && result_o.ready;
  assign same = open_q && (k == key_q);

  always_comb begin
    sum_d = sum_q; key_d = key_q; open_d = open_q; npush = 2'd0;
    r0 = '{key: key_q, sum: sum_q, fin: 1'b0};
    r1 = r0;
    if (acc) begin
      if (same) begin
        sum_d = fadd32(sum_q, edge_i.feature_value);
      end else begin
        if (open_q) npush = 2'd1;
        sum_d = edge_i.feature_value; key_d = k;
      end
      open_d = 1'b1;
      if (edge_i.end_of_stream) begin
        if (npush == 2'd1) r1 = '{key: key_d, sum: sum_d, fin: 1'b1};
        else r0 = '{key: key_d, sum: sum_d, fin: 1'b1};
        npush = npush + 2'd1;
        sum_d = 32'd0; key_d = '0; open_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= 32'd0; key_q <= '0; open_q <= 1'b0;
      cnt_q <= 2'd0; rd_ptr_q <= 1'b0; wr_ptr_q <= 1'b0;
    end else begin
      sum_q <= sum_d; key_q <= key_d; open_q <= open_d;
      if (npush != 2'd0) fifo_q[wr_ptr_q] <= r0;
      if (npush == 2'd2) fifo_q[~wr_ptr_q] <= r1;
      wr_ptr_q <= wr_ptr_q ^ npush[0];
      rd_ptr_q <= rd_ptr_q ^ pop;
      cnt_q <= cnt_q + npush - {1'b0, pop};
    end
  end

  assign result_o.valid = (cnt_q != 2'd0);
  assign result_o.result_key = fifo_q[rd_ptr_q].key;
  assign result_o.segment_sum = fifo_q[rd_ptr_q].sum;
  assign result_o.final_result = fifo_q[rd_ptr_q].fin;

`ifndef ASSERT_OFF
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("queue overflow");
  a_eos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && edge_i.end_of_stream |=> !open_q) else $error("eos did not close");
  a_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && !edge_i.end_of_stream |=> open_q) else $error("segment not open");
`endif
endmodule

[tb/tb_top.sv]
// self-checking testbench for the segmented binary32 sum unit
`timescale 1ns / 100ps

module tb_top;
  import sfs_pkg::*;

  typedef struct packed {
    logic [23:0] key;
    logic [31:0] value;
    logic        eos;
  } edge_req_t;

  typedef struct packed {
    logic [23:0] key;
    logic [31:0] sum;
    logic        last;
  } seg_result_t;

  localparam int unsigned WatchdogLimit = 20000;

  logic clk_i;
  logic rst_ni;

  sfs_edge_if   edge_bus ();
  sfs_result_if result_bus ();

  segmented_float_sum_unit u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .edge_i  (edge_bus.sink),
    .result_o(result_bus.source)
  );

  edge_req_t   pending_edges[$];
  seg_result_t expected_sums[$];

  logic [31:0] acc_sum;
  logic [23:0] acc_key;
  logic        acc_open;

  int unsigned errors;
  int unsigned phase;
  int unsigned idle_cycles;
  int unsigned hold_count;
  bit          hold_input;

  // binary32 add, round to nearest even, canonical quiet nan
  function automatic logic [31:0] sum_fp32(input logic [31:0] x, input logic [31:0] y);
    logic [31:0] a, b, s, g, d, ea, eb, ma, mb, e;
    logic        a_nan, b_nan, a_inf, b_inf;
    a_nan = (x[30:23] == 8'hFF) && (x[22:0] != 0);
    b_nan = (y[30:23] == 8'hFF) && (y[22:0] != 0);
    a_inf = (x[30:0] == 31'h7F80_0000);
    b_inf = (y[30:0] == 31'h7F80_0000);
    if (a_nan || b_nan) return 32'h7FC0_0000;
    if (a_inf && b_inf) return (x[31] != y[31]) ? 32'h7FC0_0000 : x;
    if (a_inf) return x;
    if (b_inf) return y;
    if (y[30:0] > x[30:0]) begin
      a = y; b = x;
    end else begin
      a = x; b = y;
    end
    ea = {24'd0, a[30:23]}; eb = {24'd0, b[30:23]};
    ma = {9'd0, a[22:0]}; mb = {9'd0, b[22:0]};
    if (ea == 0) ea = 1; else ma[23] = 1'b1;
    if (eb == 0) eb = 1; else mb[23] = 1'b1;
    ma = ma << 3; mb = mb << 3;
    d = ea - eb;
    if (d >= 32) mb = (mb != 0) ? 1 : 0;
    else if (d > 0) mb = (mb >> d) | (((mb & ((32'd1 << d) - 1)) != 0) ? 1 : 0);
    e = ea;
    if (a[31] == b[31]) begin
      s = ma + mb;
      if (s >= (32'd1 << 27)) begin
        s = (s >> 1) | (s & 1);
        e++;
      end
    end else begin
      s = ma - mb;
      if (s == 0) return 32'd0;
      while (s < (32'd1 << 26) && e > 1) begin
        s = s << 1;
        e--;
      end
    end
    g = s & 7;
    s = s >> 3;
    if (g > 4 || (g == 4 && s[0])) s++;
    if (s >= (32'd1 << 24)) begin
      s = s >> 1;
      e++;
    end
    if (e >= 255) return {a[31], 31'h7F80_0000};
    if (s < (32'd1 << 23)) return {a[31], s[30:0]};
    return {a[31], e[7:0], s[22:0]};
  endfunction

  function automatic void predict_segment(input edge_req_t req);
    if (acc_open && req.key == acc_key) begin
      acc_sum = sum_fp32(acc_sum, req.value);
    end else begin
      if (acc_open) expected_sums.push_back('{acc_key, acc_sum, 1'b0});
      acc_sum  = req.value;
      acc_key  = req.key;
      acc_open = 1'b1;
    end
    if (req.eos) begin
      expected_sums.push_back('{acc_key, acc_sum, 1'b1});
      acc_sum  = '0;
      acc_key  = '0;
      acc_open = 1'b0;
    end
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h7F80_0000 | ($urandom_range(1) << 31);
      1: return {$urandom_range(1) == 1, 8'hFF, 23'($urandom)};
      2: return {$urandom_range(1) == 1, 8'h00, 23'($urandom)};
      3: return {$urandom_range(1) == 1, 8'hFE, 23'($urandom)};
      4: return {$urandom_range(1) == 1, 31'd0};
      5: return {$urandom_range(1) == 1, 8'($urandom_range(120, 134)), 23'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_stream(input int unsigned n);
    logic [23:0] key;
    key = 24'($urandom);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0) key = ($urandom_range(9) == 0) ? 24'($urandom) : key + 24'd1;
      pending_edges.push_back('{key, pick_value(), i == n - 1});
    end
  endtask

  task automatic drain();
    while (pending_edges.size() != 0 || expected_sums.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_bus.valid <= 1'b0;
      edge_bus.segment_key <= '0;
      edge_bus.feature_value <= '0;
      edge_bus.end_of_stream <= 1'b0;
    end else begin
      if (edge_bus.valid && edge_bus.ready) begin
        predict_segment('{edge_bus.segment_key, edge_bus.feature_value,
                          edge_bus.end_of_stream});
        void'(pending_edges.pop_front());
      end
      if ((!edge_bus.valid || edge_bus.ready) ) begin
        // the head of the queue is what is on the bus while valid
        if (pending_edges.size() > 0 && !hold_input &&
            !((phase == 1 && $urandom_range(99) < 86) ||
              (phase == 3 && $urandom_range(99) < 12))) begin
          edge_bus.valid <= 1'b1;
          edge_bus.segment_key <= pending_edges[0].key;
          edge_bus.feature_value <= pending_edges[0].value;
          edge_bus.end_of_stream <= pending_edges[0].eos;
        end else begin
          edge_bus.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_bus.ready <= 1'b0;
      hold_count <= 0;
    end else begin
      if (result_bus.valid && result_bus.ready) begin
        if (expected_sums.size() == 0) begin
          $error("unexpected result key %h sum %h", result_bus.result_key,
                 result_bus.segment_sum);
          errors++;
        end else begin
          if (result_bus.result_key !== expected_sums[0].key) begin
            $error("result_key expected %h actual %h", expected_sums[0].key,
                   result_bus.result_key);
            errors++;
          end
          if (result_bus.segment_sum !== expected_sums[0].sum) begin
            $error("segment_sum expected %h actual %h", expected_sums[0].sum,
                   result_bus.segment_sum);
            errors++;
          end
          if (result_bus.final_result !== expected_sums[0].last) begin
            $error("final_result expected %b actual %b", expected_sums[0].last,
                   result_bus.final_result);
            errors++;
          end
          void'(expected_sums.pop_front());
        end
      end
      if (phase == 4 && hold_count < 300) begin
        hold_count <= hold_count + 1;
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= !((phase == 2 && $urandom_range(99) < 86) ||
                              (phase == 3 && $urandom_range(99) < 12));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((edge_bus.valid && edge_bus.ready) || (result_bus.valid && result_bus.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("segmented_float_sum_unit regression: fail");
      $finish;
    end
  end

  initial begin
    logic [23:0] k;
    errors = 0; phase = 0; idle_cycles = 0; hold_input = 1'b0;
    acc_sum = '0; acc_key = '0; acc_open = 1'b0;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    // first edge alone, a key that comes back, and a key change on the last edge
    k = 24'hFFFFFF;
    pending_edges.push_back('{k, 32'h3F80_0000, 1'b1});
    pending_edges.push_back('{24'h000000, 32'h3F80_0000, 1'b0});
    pending_edges.push_back('{24'h000000, 32'hBF80_0000, 1'b0});
    pending_edges.push_back('{24'h000001, 32'h8000_0000, 1'b0});
    pending_edges.push_back('{24'h000001, 32'h8000_0000, 1'b0});
    pending_edges.push_back('{24'h000002, 32'h7F80_0000, 1'b0});
    pending_edges.push_back('{24'h000002, 32'hFF80_0000, 1'b0});
    pending_edges.push_back('{24'h000003, 32'h7FFF_FFFF, 1'b0});
    pending_edges.push_back('{24'h000003, 32'h3F80_0000, 1'b0});
    pending_edges.push_back('{24'h000004, 32'h7F7F_FFFF, 1'b0});
    pending_edges.push_back('{24'h000004, 32'h7F7F_FFFF, 1'b0});
    pending_edges.push_back('{24'h000005, 32'h0000_0001, 1'b0});
    pending_edges.push_back('{24'h000005, 32'h8070_0000, 1'b0});
    pending_edges.push_back('{24'h000001, 32'hFF7F_FFFF, 1'b0});
    pending_edges.push_back('{24'h000001, 32'hFF7F_FFFF, 1'b0});
    pending_edges.push_back('{24'hAAAAAA, 32'hFFFF_FFFF, 1'b0});
    pending_edges.push_back('{24'h555555, 32'h5555_5555, 1'b1});
    drain();
    for (int p = 0; p < 5; p++) begin
      phase = p;
      for (int s = 0; s < 30; s++) queue_stream($urandom_range(1, 22));
      drain();
    end
    // sender pause until all results are in
    phase = 0;
    hold_input = 1'b1;
    drain();
    hold_input = 1'b0;
    queue_stream(40);
    drain();
    if (errors == 0 && expected_sums.size() == 0) begin
      $display("segmented_float_sum_unit regression: pass");
    end else begin
      $display("segmented_float_sum_unit regression: fail");
    end
    $finish;
  end
endmodule
